// File: rtl/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the edge/circle contact pipeline.
// ----------------------------------------------------------------------------
package ecc_pkg;

    localparam int COORD_W    = 32;               // signed Q16.16 coordinate
    localparam int RAD_W      = 31;               // unsigned Q15.16 radius
    localparam int NUM_W      = 67;               // projection numerator / denominator
    localparam int QUO_W      = 32;               // Q0.32 projection parameter
    localparam int SSQ_W      = 63;               // squared distance, Q31.32
    localparam int ROOT_W     = 32;               // distance, Q16.16
    localparam int DIV_STEPS  = QUO_W;            // one quotient bit per stage
    localparam int SQRT_STEPS = ROOT_W;           // one root bit per stage
    localparam int PIPE_DEPTH = 5 + DIV_STEPS + 4 + 3 + SQRT_STEPS + 1;

    // source of the closest point on the edge
    typedef enum logic [1:0] {
        SEL_START,
        SEL_END,
        SEL_LERP
    } t_sel;

    typedef struct packed {
        logic signed [COORD_W-1:0] edge_start_x;
        logic signed [COORD_W-1:0] edge_start_y;
        logic signed [COORD_W-1:0] edge_end_x;
        logic signed [COORD_W-1:0] edge_end_y;
        logic signed [COORD_W-1:0] body_x;
        logic signed [COORD_W-1:0] body_y;
        logic signed [COORD_W-1:0] circle_offset_x;
        logic signed [COORD_W-1:0] circle_offset_y;
        logic        [RAD_W-1:0]   radius;
    } t_in_beat;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] contact_x;
        logic signed [COORD_W-1:0] contact_y;
        logic        [RAD_W-1:0]   overlap;
    } t_out_beat;

    // per-beat state carried alongside the arithmetic
    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W:0]   cx;
        logic signed [COORD_W:0]   cy;
        logic        [RAD_W-1:0]   r;
        logic        [COORD_W:0]   dmx;
        logic        [COORD_W:0]   dmy;
        logic                      dnx;
        logic                      dny;
        t_sel                      sel;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic                      early;
        logic                      hit;
    } t_side;

endpackage

// File: rtl/ecc_in_if.sv
// ----------------------------------------------------------------------------
// ecc_in_if
// Valid/ready channel carrying one edge/circle pair per beat.
// ----------------------------------------------------------------------------
interface ecc_in_if;
    import ecc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ecc_out_if.sv
// ----------------------------------------------------------------------------
// ecc_out_if
// Valid/ready channel carrying one contact result per beat.
// ----------------------------------------------------------------------------
interface ecc_out_if;
    import ecc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ecc_div_pipe.sv
// ----------------------------------------------------------------------------
// ecc_div_pipe
// Restoring fractional divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ecc_div_pipe (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ecc_pkg::NUM_W-1:0]  i_num,
    input  logic [ecc_pkg::NUM_W-1:0]  i_den,
    output logic [ecc_pkg::QUO_W-1:0]  o_quo
);
    import ecc_pkg::*;

    logic [NUM_W-1:0] r_rem [DIV_STEPS];
    logic [NUM_W-1:0] r_den [DIV_STEPS];
    logic [QUO_W-1:0] r_quo [DIV_STEPS];

    logic [NUM_W-1:0] n_rem_in [DIV_STEPS];
    logic [NUM_W-1:0] n_den_in [DIV_STEPS];
    logic [QUO_W-1:0] n_quo_in [DIV_STEPS];
    logic [NUM_W:0]   n_sh     [DIV_STEPS];
    logic [NUM_W:0]   n_diff   [DIV_STEPS];
    logic             n_take   [DIV_STEPS];

    always_comb begin
        n_rem_in[0] = i_num;
        n_den_in[0] = i_den;
        n_quo_in[0] = '0;
        for (int k = 1; k < DIV_STEPS; k++) begin
            n_rem_in[k] = r_rem[k-1];
            n_den_in[k] = r_den[k-1];
            n_quo_in[k] = r_quo[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_sh[k]   = {n_rem_in[k], 1'b0};
            n_diff[k] = n_sh[k] - {1'b0, n_den_in[k]};
            n_take[k] = (n_sh[k] >= {1'b0, n_den_in[k]});
        end
    end

    // shift, trial subtract, keep the difference when it fits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_den[k] <= n_den_in[k];
                r_quo[k] <= {n_quo_in[k][QUO_W-2:0], n_take[k]};
                r_rem[k] <= n_take[k] ? n_diff[k][NUM_W-1:0] : n_sh[k][NUM_W-1:0];
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

// File: rtl/ecc_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// ecc_sqrt_pipe
// Floor integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ecc_sqrt_pipe (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ecc_pkg::SSQ_W-1:0]   i_val,
    output logic [ecc_pkg::ROOT_W-1:0]  o_root
);
    import ecc_pkg::*;

    localparam int RW = 2 * ROOT_W;

    logic [RW-1:0] r_val [SQRT_STEPS];
    logic [RW-1:0] r_res [SQRT_STEPS];

    logic [RW-1:0] n_val_in [SQRT_STEPS];
    logic [RW-1:0] n_res_in [SQRT_STEPS];
    logic [RW-1:0] n_bit    [SQRT_STEPS];
    logic [RW-1:0] n_trial  [SQRT_STEPS];

    always_comb begin
        n_val_in[0] = RW'(i_val);
        n_res_in[0] = '0;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            n_val_in[k] = r_val[k-1];
            n_res_in[k] = r_res[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++) begin
            n_bit[k]   = {{(RW-1){1'b0}}, 1'b1} << (RW - 2 - 2 * k);
            n_trial[k] = n_res_in[k] + n_bit[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                if (n_val_in[k] >= n_trial[k]) begin
                    r_val[k] <= n_val_in[k] - n_trial[k];
                    r_res[k] <= (n_res_in[k] >> 1) + n_bit[k];
                end else begin
                    r_val[k] <= n_val_in[k];
                    r_res[k] <= n_res_in[k] >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// File: rtl/edge_circle_contact.sv
// ----------------------------------------------------------------------------
// edge_circle_contact
// Closest-point contact test between one edge and one circle, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   i_edge carries one beat per edge/circle pair: both edge endpoints, the body
//   position and the circle centre offset in Q16.16, the radius in unsigned Q15.16.
//   o_contact carries one beat per input beat, in order: hit flag, unnormalised
//   normal (body minus closest point, saturated), contact point and overlap.
//   Without a hit every output field is zero.
// The pipeline is PIPE_DEPTH register stages deep, the last one the output register.
//   Five stages form the projection dot products, 32 divider stages give the
//   Q0.32 projection parameter, four stages interpolate the closest point,
//   three stages square the distance and 32 stages take its square root.
// Throughput: one beat per cycle while the output is not stalled; every stage is a register slice.
// Stall: the whole pipeline advances on one enable that is low only while the
//   output register holds a beat the receiver has not taken. i_edge.ready then
//   drops; nothing is lost or repeated, bubbles are not squeezed out.
// Reset: synchronous, active low; clears the valid bits, so the pipeline
//   comes out of reset empty and ready.
// ----------------------------------------------------------------------------
module edge_circle_contact (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ecc_in_if.sink    i_edge,
    ecc_out_if.source o_contact
);
    import ecc_pkg::*;

    // ------------------------------------------------------------------
    // pipeline control: one enable, valid bits shift with the data
    // ------------------------------------------------------------------
    logic                  n_en;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign n_en          = !r_vld[PIPE_DEPTH-1] || o_contact.ready;
    // hold off the sender while reset is applied
    assign i_edge.ready  = n_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_edge.valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: centre, edge vector, centre offset from start, magnitudes
    // ------------------------------------------------------------------
    t_side                   n_s1;
    logic signed [COORD_W:0]   n_dx, n_dy;
    logic signed [COORD_W+1:0] n_qx, n_qy, n_qnegx, n_qnegy;
    logic signed [COORD_W:0]   n_dnegx, n_dnegy;

    t_side            r_s1;
    logic [COORD_W:0] r1_qmx, r1_qmy;
    logic             r1_qnx, r1_qny;

    always_comb begin
        n_s1     = '0;
        n_s1.sx  = i_edge.data.edge_start_x;
        n_s1.sy  = i_edge.data.edge_start_y;
        n_s1.ex  = i_edge.data.edge_end_x;
        n_s1.ey  = i_edge.data.edge_end_y;
        n_s1.bx  = i_edge.data.body_x;
        n_s1.by  = i_edge.data.body_y;
        n_s1.r   = i_edge.data.radius;
        n_s1.cx  = {i_edge.data.body_x[COORD_W-1], i_edge.data.body_x}
                 + {i_edge.data.circle_offset_x[COORD_W-1], i_edge.data.circle_offset_x};
        n_s1.cy  = {i_edge.data.body_y[COORD_W-1], i_edge.data.body_y}
                 + {i_edge.data.circle_offset_y[COORD_W-1], i_edge.data.circle_offset_y};
        n_dx     = {n_s1.ex[COORD_W-1], n_s1.ex} - {n_s1.sx[COORD_W-1], n_s1.sx};
        n_dy     = {n_s1.ey[COORD_W-1], n_s1.ey} - {n_s1.sy[COORD_W-1], n_s1.sy};
        n_qx     = {n_s1.cx[COORD_W], n_s1.cx} - {{2{n_s1.sx[COORD_W-1]}}, n_s1.sx};
        n_qy     = {n_s1.cy[COORD_W], n_s1.cy} - {{2{n_s1.sy[COORD_W-1]}}, n_s1.sy};
        n_dnegx  = -n_dx;
        n_dnegy  = -n_dy;
        n_qnegx  = -n_qx;
        n_qnegy  = -n_qy;
        n_s1.dnx = n_dx[COORD_W];
        n_s1.dny = n_dy[COORD_W];
        n_s1.dmx = n_dx[COORD_W] ? n_dnegx : n_dx;
        n_s1.dmy = n_dy[COORD_W] ? n_dnegy : n_dy;
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_s1   <= n_s1;
            r1_qnx <= n_qx[COORD_W+1];
            r1_qny <= n_qy[COORD_W+1];
            r1_qmx <= n_qx[COORD_W+1] ? n_qnegx[COORD_W:0] : n_qx[COORD_W:0];
            r1_qmy <= n_qy[COORD_W+1] ? n_qnegy[COORD_W:0] : n_qy[COORD_W:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: partial products, multiplicand split at bit 17
    // ------------------------------------------------------------------
    t_side       r_s2;
    logic [49:0] r2_pxl, r2_pyl, r2_dxl, r2_dyl;
    logic [48:0] r2_pxh, r2_pyh, r2_dxh, r2_dyh;
    logic        r2_negx, r2_negy;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_s2    <= r_s1;
            r2_negx <= r1_qnx ^ r_s1.dnx;
            r2_negy <= r1_qny ^ r_s1.dny;
            r2_pxl  <= r1_qmx[16:0] * r_s1.dmx;
            r2_pxh  <= r1_qmx[COORD_W:17] * r_s1.dmx;
            r2_pyl  <= r1_qmy[16:0] * r_s1.dmy;
            r2_pyh  <= r1_qmy[COORD_W:17] * r_s1.dmy;
            r2_dxl  <= r_s1.dmx[16:0] * r_s1.dmx;
            r2_dxh  <= r_s1.dmx[COORD_W:17] * r_s1.dmx;
            r2_dyl  <= r_s1.dmy[16:0] * r_s1.dmy;
            r2_dyh  <= r_s1.dmy[COORD_W:17] * r_s1.dmy;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: combine partial products
    // ------------------------------------------------------------------
    t_side       r_s3;
    logic [65:0] r3_px, r3_py, r3_dxx, r3_dyy;
    logic        r3_negx, r3_negy;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_s3    <= r_s2;
            r3_negx <= r2_negx;
            r3_negy <= r2_negy;
            r3_px   <= 66'(r2_pxl) + {r2_pxh, 17'b0};
            r3_py   <= 66'(r2_pyl) + {r2_pyh, 17'b0};
            r3_dxx  <= 66'(r2_dxl) + {r2_dxh, 17'b0};
            r3_dyy  <= 66'(r2_dyl) + {r2_dyh, 17'b0};
        end
    end

    // ------------------------------------------------------------------
    // stage 4: signed numerator S.D and denominator D.D
    // ------------------------------------------------------------------
    logic signed [NUM_W:0] n_tx, n_ty;
    t_side                 r_s4;
    logic signed [NUM_W:0] r4_num;
    logic [NUM_W-1:0]      r4_den;

    always_comb begin
        n_tx = $signed({2'b00, r3_px});
        n_ty = $signed({2'b00, r3_py});
        if (r3_negx) begin
            n_tx = -n_tx;
        end
        if (r3_negy) begin
            n_ty = -n_ty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_s4   <= r_s3;
            r4_num <= n_tx + n_ty;
            r4_den <= NUM_W'(r3_dxx) + NUM_W'(r3_dyy);
        end
    end

    // ------------------------------------------------------------------
    // stage 5: clamp decision; a zero-length edge lands on the start point
    // ------------------------------------------------------------------
    t_side            n_s5;
    t_side            r_s5;
    logic [NUM_W-1:0] r5_num, r5_den;

    always_comb begin
        n_s5 = r_s4;
        if (r4_num[NUM_W] || (r4_num == '0)) begin
            n_s5.sel = SEL_START;
        end else if (r4_num[NUM_W-1:0] >= r4_den) begin
            n_s5.sel = SEL_END;
        end else begin
            n_s5.sel = SEL_LERP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_s5   <= n_s5;
            r5_num <= r4_num[NUM_W-1:0];
            r5_den <= r4_den;
        end
    end

    // ------------------------------------------------------------------
    // divider: t = floor(num * 2^32 / den), side data delayed alongside
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] n_t;
    t_side            r_sdiv [DIV_STEPS];

    ecc_div_pipe u_div (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (r5_num),
        .i_den (r5_den),
        .o_quo (n_t)
    );

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sdiv[0] <= r_s5;
            for (int k = 1; k < DIV_STEPS; k++) begin
                r_sdiv[k] <= r_sdiv[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // lerp stage 1: |D| * t partial products
    // ------------------------------------------------------------------
    t_side       r_l1;
    logic [48:0] r_l1_xl, r_l1_yl;
    logic [47:0] r_l1_xh, r_l1_yh;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_l1    <= r_sdiv[DIV_STEPS-1];
            r_l1_xl <= r_sdiv[DIV_STEPS-1].dmx[16:0] * n_t;
            r_l1_xh <= r_sdiv[DIV_STEPS-1].dmx[COORD_W:17] * n_t;
            r_l1_yl <= r_sdiv[DIV_STEPS-1].dmy[16:0] * n_t;
            r_l1_yh <= r_sdiv[DIV_STEPS-1].dmy[COORD_W:17] * n_t;
        end
    end

    // lerp stage 2: combine
    t_side       r_l2;
    logic [64:0] r_l2_ox, r_l2_oy;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_l2    <= r_l1;
            r_l2_ox <= 65'(r_l1_xl) + {r_l1_xh, 17'b0};
            r_l2_oy <= 65'(r_l1_yl) + {r_l1_yh, 17'b0};
        end
    end

    // lerp stage 3: round half up and drop 32 fraction bits
    logic [65:0]      n_rx, n_ry;
    t_side            r_l3;
    logic [COORD_W:0] r_l3_offx, r_l3_offy;

    assign n_rx = 66'(r_l2_ox) + 66'h0_8000_0000;
    assign n_ry = 66'(r_l2_oy) + 66'h0_8000_0000;

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_l3      <= r_l2;
            r_l3_offx <= n_rx[64:32];
            r_l3_offy <= n_ry[64:32];
        end
    end

    // lerp stage 4: pick the closest point
    logic signed [COORD_W+1:0] n_lx, n_ly;
    t_side                     n_l4;
    t_side                     r_l4;

    always_comb begin
        n_l4 = r_l3;
        if (r_l3.dnx) begin
            n_lx = {{2{r_l3.sx[COORD_W-1]}}, r_l3.sx} - $signed({1'b0, r_l3_offx});
        end else begin
            n_lx = {{2{r_l3.sx[COORD_W-1]}}, r_l3.sx} + $signed({1'b0, r_l3_offx});
        end
        if (r_l3.dny) begin
            n_ly = {{2{r_l3.sy[COORD_W-1]}}, r_l3.sy} - $signed({1'b0, r_l3_offy});
        end else begin
            n_ly = {{2{r_l3.sy[COORD_W-1]}}, r_l3.sy} + $signed({1'b0, r_l3_offy});
        end
        case (r_l3.sel)
            SEL_END: begin
                n_l4.px = r_l3.ex;
                n_l4.py = r_l3.ey;
            end
            SEL_LERP: begin
                n_l4.px = n_lx[COORD_W-1:0];
                n_l4.py = n_ly[COORD_W-1:0];
            end
            default: begin
                n_l4.px = r_l3.sx;
                n_l4.py = r_l3.sy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_l4 <= n_l4;
        end
    end

    // ------------------------------------------------------------------
    // distance stage 1: centre minus closest point, saturated normal
    // ------------------------------------------------------------------
    logic signed [COORD_W+1:0] n_ddx, n_ddy, n_ddnx, n_ddny;
    logic signed [COORD_W:0]   n_nbx, n_nby;
    t_side                     n_d1;
    t_side                     r_d1;
    logic [COORD_W:0]          r_d1_mx, r_d1_my;

    always_comb begin
        n_d1   = r_l4;
        n_ddx  = {r_l4.cx[COORD_W], r_l4.cx} - {{2{r_l4.px[COORD_W-1]}}, r_l4.px};
        n_ddy  = {r_l4.cy[COORD_W], r_l4.cy} - {{2{r_l4.py[COORD_W-1]}}, r_l4.py};
        n_ddnx = -n_ddx;
        n_ddny = -n_ddy;
        n_nbx  = {r_l4.bx[COORD_W-1], r_l4.bx} - {r_l4.px[COORD_W-1], r_l4.px};
        n_nby  = {r_l4.by[COORD_W-1], r_l4.by} - {r_l4.py[COORD_W-1], r_l4.py};
        // saturate where the top two bits disagree
        if (n_nbx[COORD_W] != n_nbx[COORD_W-1]) begin
            n_d1.nx = n_nbx[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            n_d1.nx = n_nbx[COORD_W-1:0];
        end
        if (n_nby[COORD_W] != n_nby[COORD_W-1]) begin
            n_d1.ny = n_nby[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            n_d1.ny = n_nby[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_d1    <= n_d1;
            r_d1_mx <= n_ddx[COORD_W+1] ? n_ddnx[COORD_W:0] : n_ddx[COORD_W:0];
            r_d1_my <= n_ddy[COORD_W+1] ? n_ddny[COORD_W:0] : n_ddy[COORD_W:0];
        end
    end

    // distance stage 2: early miss on either axis, squares
    t_side             n_d2;
    t_side             r_d2;
    logic [2*RAD_W-1:0] r_d2_sqx, r_d2_sqy, r_d2_rr;

    always_comb begin
        n_d2       = r_d1;
        n_d2.early = (r_d1_mx >= (COORD_W+1)'(r_d1.r)) || (r_d1_my >= (COORD_W+1)'(r_d1.r));
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_d2     <= n_d2;
            r_d2_sqx <= r_d1_mx[RAD_W-1:0] * r_d1_mx[RAD_W-1:0];
            r_d2_sqy <= r_d1_my[RAD_W-1:0] * r_d1_my[RAD_W-1:0];
            r_d2_rr  <= r_d1.r * r_d1.r;
        end
    end

    // distance stage 3: sum of squares against radius squared
    logic [SSQ_W-1:0] n_ssq;
    t_side            n_d3;
    t_side            r_d3;
    logic [SSQ_W-1:0] r_d3_ssq;

    always_comb begin
        n_ssq    = SSQ_W'(r_d2_sqx) + SSQ_W'(r_d2_sqy);
        n_d3     = r_d2;
        n_d3.hit = !r_d2.early && (n_ssq < SSQ_W'(r_d2_rr));
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_d3     <= n_d3;
            r_d3_ssq <= n_ssq;
        end
    end

    // ------------------------------------------------------------------
    // square root of the squared distance
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] n_root;
    t_side             r_ssq [SQRT_STEPS];

    ecc_sqrt_pipe u_sqrt (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_val  (r_d3_ssq),
        .o_root (n_root)
    );

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_ssq[0] <= r_d3;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_ssq[k] <= r_ssq[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: zero every field on a miss
    // ------------------------------------------------------------------
    t_side     n_fin;
    t_out_beat n_out;
    t_out_beat r_out;

    always_comb begin
        n_fin = r_ssq[SQRT_STEPS-1];
        n_out = '0;
        if (n_fin.hit) begin
            n_out.hit       = 1'b1;
            n_out.normal_x  = n_fin.nx;
            n_out.normal_y  = n_fin.ny;
            n_out.contact_x = n_fin.px;
            n_out.contact_y = n_fin.py;
            n_out.overlap   = n_fin.r - n_root[RAD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out <= n_out;
        end
    end

    assign o_contact.valid = r_vld[PIPE_DEPTH-1];
    assign o_contact.data  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_contact.valid && !o_contact.data.hit |->
            o_contact.data.overlap == '0 && o_contact.data.contact_x == '0 &&
            o_contact.data.contact_y == '0 && o_contact.data.normal_x == '0 &&
            o_contact.data.normal_y == '0)
        else $error("miss beat carries non-zero fields");

    a_hit_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_contact.valid && o_contact.data.hit |-> o_contact.data.overlap != '0)
        else $error("hit beat with zero overlap");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_contact.valid && !o_contact.ready |-> !i_edge.ready)
        else $error("input taken while output stalled");

endmodule

// File: verif/tb_ecc_chan_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ecc_chan_if
// Testbench package only; the block's own channel interfaces are used by the bench.
// ----------------------------------------------------------------------------
package tb_ecc_pkg;
    import ecc_pkg::*;

    // which point of the edge the closest point comes from
    typedef enum int {
        PT_START,
        PT_END,
        PT_LERP
    } t_pt_src;
endpackage

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the edge/circle contact pipeline.
// A directed table covers extremes and special cases, then random edge/circle
// pairs stream in with random gaps and receiver stalls; each output beat is
// checked field by field against a table result or a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb;
    import ecc_pkg::*;
    import tb_ecc_pkg::*;

    localparam int N_RANDOM = 1250;
    localparam int N_DIR    = 12;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ecc_in_if  edge_ch ();
    ecc_out_if cont_ch ();

    edge_circle_contact dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_edge    (edge_ch.sink),
        .o_contact (cont_ch.source)
    );

    always #10 i_clk = ~i_clk;

    t_out_beat contact_q[$];
    int        n_bad = 0;
    bit        feeding_done = 1'b0;
    bit        long_stall = 1'b0;

    // ------------------------------------------------------------------
    // Contact predictor. Wide exact arithmetic in 140-bit signed vectors.
    // ------------------------------------------------------------------
    function automatic logic [31:0] sat_coord(logic signed [139:0] v);
        if (v > 140'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -140'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // floor square root of a value below 2^64
    function automatic logic [63:0] floor_root(logic [127:0] v);
        logic [127:0] res;
        logic [127:0] bitv;
        res  = 0;
        bitv = 128'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[63:0];
    endfunction

    function automatic logic signed [139:0] interp(logic signed [139:0] st,
                                                   logic signed [139:0] dv,
                                                   logic [139:0] t);
        logic [139:0] m;
        logic [139:0] off;
        m   = (dv < 0) ? -dv : dv;
        off = (m * t + 140'h8000_0000) >> 32;
        return (dv < 0) ? st - $signed(off) : st + $signed(off);
    endfunction

    function automatic t_out_beat predict_contact(t_in_beat b);
        logic signed [139:0] sx, sy, ex, ey, bx, by, cx, cy, dxe, dye, qx, qy;
        logic signed [139:0] num, den, px, py, ddx, ddy, mx, my;
        logic [139:0] t, r, ssq;
        t_pt_src src;
        t_out_beat o;
        sx = b.edge_start_x; sy = b.edge_start_y;
        ex = b.edge_end_x;   ey = b.edge_end_y;
        bx = b.body_x;       by = b.body_y;
        cx = bx + 140'(b.circle_offset_x);
        cy = by + 140'(b.circle_offset_y);
        r  = 140'(b.radius);
        dxe = ex - sx; dye = ey - sy;
        qx  = cx - sx; qy  = cy - sy;
        num = qx * dxe + qy * dye;
        den = dxe * dxe + dye * dye;
        if (num <= 0) src = PT_START;
        else if (num >= den) src = PT_END;
        else src = PT_LERP;
        case (src)
            PT_START: begin px = sx; py = sy; end
            PT_END: begin px = ex; py = ey; end
            default: begin
                t  = ($unsigned(num) << 32) / $unsigned(den);
                px = interp(sx, dxe, t);
                py = interp(sy, dye, t);
            end
        endcase
        o = '0;
        ddx = cx - px; ddy = cy - py;
        mx = (ddx < 0) ? -ddx : ddx;
        my = (ddy < 0) ? -ddy : ddy;
        if ($unsigned(mx) >= r || $unsigned(my) >= r) return o;
        ssq = mx * mx + my * my;
        if (ssq >= r * r) return o;
        o.hit       = 1'b1;
        o.normal_x  = sat_coord(bx - px);
        o.normal_y  = sat_coord(by - py);
        o.contact_x = px[31:0];
        o.contact_y = py[31:0];
        o.overlap   = 31'(r - 140'(floor_root(ssq[127:0])));
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [31:0] rnd_coord(int span);
        // span 0: full 32-bit range; otherwise a small signed window
        if (span == 0) return $urandom;
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Mostly near-contact geometry so hits are common; some full-range noise.
    function automatic t_in_beat random_pair();
        t_in_beat b;
        int kind, span;
        kind = $urandom_range(9);
        span = (kind < 3) ? 32'h0002_0000 : (kind < 7) ? 32'h0100_0000 : 0;
        b.edge_start_x    = rnd_coord(span);
        b.edge_start_y    = rnd_coord(span);
        b.edge_end_x      = ($urandom_range(15) == 0) ? b.edge_start_x : rnd_coord(span);
        b.edge_end_y      = ($urandom_range(15) == 0) ? b.edge_start_y : rnd_coord(span);
        b.body_x          = rnd_coord(span);
        b.body_y          = rnd_coord(span);
        b.circle_offset_x = (kind == 9) ? rnd_coord(0) : rnd_coord(span / 16 + 1);
        b.circle_offset_y = (kind == 9) ? rnd_coord(0) : rnd_coord(span / 16 + 1);
        if (span == 0 || $urandom_range(7) == 0) b.radius = 31'($urandom);
        else b.radius = 31'($urandom_range(2 * span));
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Directed table: stimulus, and an expected result where obvious
    // ------------------------------------------------------------------
    typedef struct {
        t_in_beat  stim;
        bit        typed;
        t_out_beat want;
    } t_dir_row;

    t_dir_row dir_rows[N_DIR];

    function automatic t_in_beat pair(int sx, int sy, int ex, int ey, int bx, int by,
                                      int ox, int oy, logic [30:0] r);
        t_in_beat b;
        b.edge_start_x = sx; b.edge_start_y = sy;
        b.edge_end_x = ex;   b.edge_end_y = ey;
        b.body_x = bx;       b.body_y = by;
        b.circle_offset_x = ox; b.circle_offset_y = oy;
        b.radius = r;
        return b;
    endfunction

    task automatic build_table();
        localparam int ONE = 32'h0001_0000;
        localparam int MX  = 32'h7FFF_FFFF;
        localparam int MN  = 32'h8000_0000;
        t_out_beat z;
        z = '0;
        foreach (dir_rows[k]) begin
            dir_rows[k].typed = 1'b0;
            dir_rows[k].want  = z;
        end
        // zero radius: never a hit
        dir_rows[0].stim = pair(0, 0, ONE, 0, 0, 0, 0, 0, '0);
        dir_rows[0].typed = 1'b1;
        // centre on the start point of a degenerate edge, radius one
        dir_rows[1].stim = pair(ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 31'(ONE));
        dir_rows[1].typed = 1'b1;
        dir_rows[1].want.hit = 1'b1;
        dir_rows[1].want.contact_x = ONE;
        dir_rows[1].want.contact_y = ONE;
        dir_rows[1].want.overlap = 31'(ONE);
        // distance exactly equal to radius: no hit
        dir_rows[2].stim = pair(0, 0, 4 * ONE, 0, 2 * ONE, ONE, 0, 0, 31'(ONE));
        dir_rows[2].typed = 1'b1;
        // centre beyond start, beyond end, inside the span
        dir_rows[3].stim = pair(0, 0, 4 * ONE, 0, -ONE / 2, 0, 0, 0, 31'(ONE));
        dir_rows[4].stim = pair(0, 0, 4 * ONE, 0, 5 * ONE, ONE / 4, -ONE / 2, 0, 31'(ONE));
        dir_rows[5].stim = pair(ONE, -ONE, -3 * ONE, 2 * ONE, 0, 0, ONE / 8, ONE / 3,
                                31'(2 * ONE));
        // extremes: edges and bodies at the corners of the range, maximum radius
        dir_rows[6].stim = pair(MN, MN, MX, MX, MX, MN, MX, MN, 31'h7FFF_FFFF);
        dir_rows[7].stim = pair(MX, MX, MN, MN, MN, MX, MN, MX, 31'h7FFF_FFFF);
        dir_rows[8].stim = pair(MN, MX, MN, MX, MN, MX, MX, MN, 31'h7FFF_FFFF);
        // normal saturation: body far from the edge, offset pulls centre back
        dir_rows[9].stim = pair(MX, MX, MX, MX, MN, MN, MX, MX, 31'h7FFF_FFFF);
        dir_rows[10].stim = pair(MN, MN, MN, MN, MX, MX, MN, MN, 31'h7FFF_FFFF);
        // coordinates of plus or minus one LSB, radius three LSB
        dir_rows[11].stim = pair(-1, -1, 1, 1, -1, 1, 0, 0, 31'd3);
    endtask

    // ------------------------------------------------------------------
    // Sender: drive on the falling edge, hold until accepted; valid stays
    // high into the next beat when there is no gap
    // ------------------------------------------------------------------
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = ($urandom_range(9) < 6) ? 0 :
              ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(3);
        if (gap != 0) begin
            edge_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.data  <= b;
        @(posedge i_clk);
        while (!edge_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_in_beat b;
        edge_ch.valid = 1'b0;
        edge_ch.data  = '0;
        build_table();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < N_DIR; k++) send_beat(dir_rows[k].stim);
        for (int k = 0; k < N_RANDOM; k++) begin
            // hold the receiver off for a long stretch part way through
            if (k == 300) long_stall = 1'b1;
            send_beat(random_pair());
        end
        edge_ch.valid <= 1'b0;
        feeding_done = 1'b1;
    end

    // record expectations at each accepted input beat
    int dir_idx = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && edge_ch.valid && edge_ch.ready) begin
            if (dir_idx < N_DIR && dir_rows[dir_idx].typed)
                contact_q.push_back(dir_rows[dir_idx].want);
            else
                contact_q.push_back(predict_contact(edge_ch.data));
            dir_idx++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        cont_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_stall) begin
                cont_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_stall = 1'b0;
                cont_ch.ready <= 1'b1;
            end else if ($urandom_range(99) < 50) begin
                cont_ch.ready <= 1'b1;
            end else begin
                cont_ch.ready <= ($urandom_range(9) < 3) ? 1'b0 : 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each accepted output beat with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_beat want, got;
        if (i_rst_n && cont_ch.valid && cont_ch.ready) begin
            got = cont_ch.data;
            if (contact_q.size() == 0) begin
                $error("output beat with no expectation waiting");
                n_bad++;
            end else begin
                want = contact_q.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit); n_bad++;
                end
                if (got.normal_x !== want.normal_x) begin
                    $error("normal_x: expected %0d, got %0d", want.normal_x, got.normal_x);
                    n_bad++;
                end
                if (got.normal_y !== want.normal_y) begin
                    $error("normal_y: expected %0d, got %0d", want.normal_y, got.normal_y);
                    n_bad++;
                end
                if (got.contact_x !== want.contact_x) begin
                    $error("contact_x: expected %0d, got %0d", want.contact_x, got.contact_x);
                    n_bad++;
                end
                if (got.contact_y !== want.contact_y) begin
                    $error("contact_y: expected %0d, got %0d", want.contact_y, got.contact_y);
                    n_bad++;
                end
                if (got.overlap !== want.overlap) begin
                    $error("overlap: expected %0d, got %0d", want.overlap, got.overlap);
                    n_bad++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run: drain, then let the pipeline latency pass
    // ------------------------------------------------------------------
    initial begin
        wait (feeding_done);
        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (n_bad == 0 && contact_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // time limit, far beyond what 1262 beats with their gaps and stalls need
    initial begin
        #(20 * 2_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
